// ----- rtl/scc_bank_mapper_with_ram_mode_assert.svh -----
// Assertion macros for the checker file.
`ifndef SCC_BANK_MAPPER_WITH_RAM_MODE_ASSERT_SVH
`define SCC_BANK_MAPPER_WITH_RAM_MODE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define SCCBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define SCCBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sccbm_pkg.sv -----
package sccbm_pkg;

  // Access kinds carried on the input tuser
  localparam logic [1:0] FUNC_READ    = 2'd0;
  localparam logic [1:0] FUNC_WRITE   = 2'd1;
  localparam logic [1:0] FUNC_PRELOAD = 2'd2;

  // Store geometry
  localparam int BANK_BYTES         = 8192;
  localparam int REGION_COUNT       = 4;
  localparam int DEF_BANK_COUNT     = 32;
  localparam int DEF_ROM_BANK_COUNT = 16;
  localparam int FULL_AW            = 19;  // byte address wide enough for 64 banks

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int CPU_AW   = 15;
  localparam int STORE_AW = 17;
  localparam int DATA_W   = 8;
  localparam int OFF_W    = 13;
  localparam int BANK_W   = 5;
  localparam int SEL_W    = 6;
  localparam int IN_TDATA_W = 40;

  // Register decode constants
  localparam logic [CPU_AW-1:0] REG_AREA_MASK  = 15'h7800;
  localparam logic [CPU_AW-1:0] REG_AREA_MATCH = 15'h0800;
  localparam logic [CPU_AW-1:0] BANK_WIN_MASK  = 15'h1800;
  localparam logic [CPU_AW-1:0] BANK_WIN_MATCH = 15'h1000;
  localparam logic [7:0]        LOW_MODE       = 8'hFB;
  localparam logic [7:0]        LOW_BANK_FIRST = 8'hFC;
  localparam logic [DATA_W-1:0] OPEN_BUS       = 8'hFF;

  // Read result queue
  localparam int OUT_DEPTH = 3;
  localparam int OUT_PW    = 2;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } rd_beat_t;

endpackage

// ----- rtl/sccbm_out_fifo.sv -----
module sccbm_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sccbm_pkg::rd_beat_t           push_i,
  output logic [sccbm_pkg::OUT_PW-1:0]  count_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [sccbm_pkg::DATA_W-1:0]  m_axis_tdata_o   // read_data
);

  logic [sccbm_pkg::DATA_W-1:0] entry_q [sccbm_pkg::OUT_DEPTH];
  logic [sccbm_pkg::OUT_PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [sccbm_pkg::OUT_PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [sccbm_pkg::OUT_PW-1:0] count_q, count_d;
  logic                         pop;

  localparam logic [sccbm_pkg::OUT_PW-1:0] LAST_PTR =
    sccbm_pkg::OUT_PW'(sccbm_pkg::OUT_DEPTH - 1);

  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = entry_q[rd_ptr_q];
  assign count_o         = count_q;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i.valid, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold the beat data
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule

// ----- rtl/scc_bank_mapper_with_ram_mode.sv -----
// Cartridge bank mapper with a RAM mode over a byte store of BANK_COUNT banks of
// 8 KB; banks below ROM_BANK_COUNT are ROM (filled by preload beats), the rest RAM.
// One beat is taken every cycle while tready is high; a read answers on the
// master side after its beat passes the store's registered read port and then
// the three-entry result queue, and backpressure there stalls the slave side
// only once the queued reads and the read in flight fill those three entries.
// Writes and preloads give no beat. After reset the RAM banks are zeroed one
// byte a cycle, with tready low; ROM contents survive reset.
module scc_bank_mapper_with_ram_mode #(
  parameter int BANK_COUNT     = sccbm_pkg::DEF_BANK_COUNT,
  parameter int ROM_BANK_COUNT = sccbm_pkg::DEF_ROM_BANK_COUNT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: cpu_address[14:0], store_address[31:15], data[39:32]
  input  logic [sccbm_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: func[1:0]
  input  logic [sccbm_pkg::FUNC_W-1:0]     s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: read_data[7:0]
  output logic [sccbm_pkg::DATA_W-1:0]     m_axis_tdata_o
);

  localparam int ROM_BANKS   = (ROM_BANK_COUNT < BANK_COUNT) ? ROM_BANK_COUNT : BANK_COUNT;
  localparam int STORE_BYTES = BANK_COUNT * sccbm_pkg::BANK_BYTES;
  localparam int ROM_END     = ROM_BANKS * sccbm_pkg::BANK_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CLR_W       = ADDR_W + 1;
  localparam int LIM_W       = 7;
  localparam int PRE_W       = sccbm_pkg::FULL_AW + 1;
  localparam logic HAS_RAM   = (ROM_END < STORE_BYTES);
  localparam logic [LIM_W-1:0] BANK_LIM = LIM_W'(BANK_COUNT);
  localparam logic [LIM_W-1:0] ROM_LIM  = LIM_W'(ROM_BANK_COUNT);

  // Input beat fields
  logic                              acc;
  logic [sccbm_pkg::FUNC_W-1:0]      func;
  logic [sccbm_pkg::CPU_AW-1:0]      cpu_addr;
  logic [sccbm_pkg::STORE_AW-1:0]    st_addr;
  logic [sccbm_pkg::DATA_W-1:0]      wdata;

  assign acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign func     = s_axis_tuser_i;
  assign cpu_addr = s_axis_tdata_i[14:0];
  assign st_addr  = s_axis_tdata_i[31:15];
  assign wdata    = s_axis_tdata_i[39:32];

  // Mapper state
  logic [sccbm_pkg::SEL_W-1:0] bank_sel_q [sccbm_pkg::REGION_COUNT];
  logic [sccbm_pkg::SEL_W-1:0] bank_sel_d [sccbm_pkg::REGION_COUNT];
  logic                        ram_mode_q, ram_mode_d;

  // Clearing pass over the RAM banks
  logic             clear_q, clear_d;
  logic [CLR_W-1:0] clr_addr_q, clr_addr_d;

  // Read pipeline
  logic                         p1_read_q;
  logic                         p1_oob_q;
  logic [sccbm_pkg::DATA_W-1:0] rd_q;
  logic [sccbm_pkg::OUT_PW-1:0] q_count;
  sccbm_pkg::rd_beat_t          push;

  // Store ports
  logic [sccbm_pkg::DATA_W-1:0] mem [STORE_BYTES];
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_wa;
  logic [sccbm_pkg::DATA_W-1:0] mem_wd;
  logic                         mem_re;

  // Address decode
  logic [1:0]                   region;
  logic [sccbm_pkg::BANK_W-1:0] bank;
  logic [LIM_W-1:0]             bank_x;
  logic [sccbm_pkg::FULL_AW-1:0] cpu_full;
  logic                         in_reg_area;
  logic                         low_mode;
  logic                         low_bank;
  logic                         store_hit;
  logic                         pre_hit;

  assign region      = cpu_addr[14:13];
  assign bank        = bank_sel_q[region][sccbm_pkg::BANK_W-1:0];
  assign bank_x      = LIM_W'(bank);
  assign cpu_full    = sccbm_pkg::FULL_AW'({bank, cpu_addr[sccbm_pkg::OFF_W-1:0]});
  assign in_reg_area = ((cpu_addr & sccbm_pkg::REG_AREA_MASK) == sccbm_pkg::REG_AREA_MATCH);
  assign low_mode    = (cpu_addr[7:0] == sccbm_pkg::LOW_MODE);
  assign low_bank    = (cpu_addr[7:0] >= sccbm_pkg::LOW_BANK_FIRST);
  assign pre_hit     = (PRE_W'(st_addr) < PRE_W'(ROM_END));

  // Decode register writes; the mode register wins, then bank registers
  always_comb begin
    for (int r = 0; r < sccbm_pkg::REGION_COUNT; r++) begin
      bank_sel_d[r] = bank_sel_q[r];
    end
    ram_mode_d = ram_mode_q;
    store_hit  = 1'b0;
    if (acc && (func == sccbm_pkg::FUNC_WRITE)) begin
      priority if (in_reg_area && low_mode) begin
        ram_mode_d = wdata[0];
      end else if (ram_mode_q && in_reg_area && low_bank) begin
        bank_sel_d[cpu_addr[1:0]] = wdata[sccbm_pkg::SEL_W-1:0];
      end else if (!ram_mode_q &&
                   ((cpu_addr & sccbm_pkg::BANK_WIN_MASK) == sccbm_pkg::BANK_WIN_MATCH)) begin
        bank_sel_d[region] = wdata[sccbm_pkg::SEL_W-1:0];
      end else begin
        store_hit = ram_mode_q && (bank_x >= ROM_LIM) && (bank_x < BANK_LIM);
      end
    end
  end

  // Advance the clearing pass
  always_comb begin
    clear_d    = clear_q;
    clr_addr_d = clr_addr_q;
    if (clear_q) begin
      if (clr_addr_q == CLR_W'(STORE_BYTES - 1)) begin
        clear_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  // Pick the single store write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr_q[ADDR_W-1:0];
    mem_wd = '0;
    priority if (clear_q) begin
      mem_we = 1'b1;
    end else if (acc && (func == sccbm_pkg::FUNC_WRITE) && store_hit) begin
      mem_we = 1'b1;
      mem_wa = cpu_full[ADDR_W-1:0];
      mem_wd = wdata;
    end else if (acc && (func == sccbm_pkg::FUNC_PRELOAD) && pre_hit) begin
      mem_we = 1'b1;
      mem_wa = ADDR_W'(st_addr);
      mem_wd = wdata;
    end else begin
      mem_we = 1'b0;
    end
  end

  assign mem_re = acc && (func == sccbm_pkg::FUNC_READ);

  // Byte store with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q     <= mem[cpu_full[ADDR_W-1:0]];
      p1_oob_q <= (bank_x >= BANK_LIM);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < sccbm_pkg::REGION_COUNT; r++) begin
        bank_sel_q[r] <= sccbm_pkg::SEL_W'(r);
      end
      ram_mode_q <= 1'b0;
      clear_q    <= HAS_RAM;
      clr_addr_q <= CLR_W'(ROM_END);
      p1_read_q  <= 1'b0;
    end else begin
      for (int r = 0; r < sccbm_pkg::REGION_COUNT; r++) begin
        bank_sel_q[r] <= bank_sel_d[r];
      end
      ram_mode_q <= ram_mode_d;
      clear_q    <= clear_d;
      clr_addr_q <= clr_addr_d;
      p1_read_q  <= mem_re;
    end
  end

  // Take a beat only when no clearing pass runs and the queue has room for every read in flight
  assign s_axis_tready_o = !clear_q &&
    ((3'({1'b0, q_count}) + 3'(p1_read_q)) < 3'(sccbm_pkg::OUT_DEPTH));

  assign push.valid = p1_read_q;
  assign push.data  = p1_oob_q ? sccbm_pkg::OPEN_BUS : rd_q;

  sccbm_out_fifo u_out_fifo (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .count_o         (q_count),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ----- rtl/sccbm_checker.sv -----
`include "scc_bank_mapper_with_ram_mode_assert.svh"

module sccbm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [sccbm_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  input logic [sccbm_pkg::FUNC_W-1:0]     s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [sccbm_pkg::DATA_W-1:0]     m_axis_tdata_o
);

  logic rd_acc;

  assign rd_acc = s_axis_tvalid_i && s_axis_tready_o &&
                  (s_axis_tuser_i == sccbm_pkg::FUNC_READ);

  // A stalled result beat holds
  `SCCBM_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result beat changed while stalled")

  // A taken read shows a result after the store read and queue registers
  `SCCBM_ASSERT_IMP(a_read_answers, rd_acc, ##2 m_axis_tvalid_o, "read gave no result beat")

  // A result only appears after a taken read
  `SCCBM_ASSERT_IMP(a_no_invented, $rose(m_axis_tvalid_o), $past(rd_acc, 2), "result beat without a read")

endmodule

bind scc_bank_mapper_with_ram_mode sccbm_checker u_sccbm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- tb/sccbm_read_checker.sv -----
`timescale 1ns / 1ps

// Watches both stream channels of the bank mapper, keeps its own image of the
// bank registers, the RAM mode flag and the byte store, and checks every read
// beat against the byte that the image says the mapped bank holds.
module sccbm_read_checker
  import sccbm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [IN_TDATA_W-1:0] in_data_i,
  input  logic [FUNC_W-1:0]     in_user_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [DATA_W-1:0]     out_data_i,
  output int                    fail_count_o,
  output int                    reads_owed_o
);

  localparam int StoreBytes = DEF_BANK_COUNT * BANK_BYTES;
  localparam int RomBytes   = DEF_ROM_BANK_COUNT * BANK_BYTES;

  logic [SEL_W-1:0]  bank_sel [REGION_COUNT];
  logic              ram_mode;
  logic [DATA_W-1:0] store_img [StoreBytes];
  logic [DATA_W-1:0] read_bytes_q [$];
  int                mismatches;
  int                read_beats;

  // Start from the reset image: registers 0..3, RAM zero, ROM unknown until preloaded
  initial begin : image_init
    int idx;
    for (idx = 0; idx < REGION_COUNT; idx++) bank_sel[idx] = SEL_W'(idx);
    ram_mode = 1'b0;
    for (idx = 0; idx < StoreBytes; idx++) begin
      if (idx < RomBytes) store_img[idx] = 'x;
      else store_img[idx] = '0;
    end
    mismatches   = 0;
    read_beats   = 0;
    fail_count_o = 0;
    reads_owed_o = 0;
  end

  // Byte that a CPU read of addr returns
  function automatic logic [DATA_W-1:0] bank_byte(input logic [CPU_AW-1:0] addr);
    int bank;
    bank = int'(bank_sel[addr[CPU_AW-1:OFF_W]][BANK_W-1:0]);
    if (bank < DEF_BANK_COUNT) return store_img[bank * BANK_BYTES + int'(addr[OFF_W-1:0])];
    return OPEN_BUS;
  endfunction

  // Decode a CPU write into a mode change, a bank change or a RAM store
  task automatic cpu_write(input logic [CPU_AW-1:0] addr, input logic [DATA_W-1:0] val);
    logic [1:0] region;
    logic       in_regs;
    int         bank;
    region  = addr[CPU_AW-1:OFF_W];
    in_regs = (addr & REG_AREA_MASK) == REG_AREA_MATCH;
    if (in_regs && addr[7:0] == LOW_MODE) begin
      ram_mode = val[0];
    end else if (ram_mode && in_regs && addr[7:0] >= LOW_BANK_FIRST) begin
      bank_sel[addr[1:0]] = val[SEL_W-1:0];
    end else if (!ram_mode && (addr & BANK_WIN_MASK) == BANK_WIN_MATCH) begin
      bank_sel[region] = val[SEL_W-1:0];
    end else begin
      bank = int'(bank_sel[region][BANK_W-1:0]);
      if (ram_mode && bank >= DEF_ROM_BANK_COUNT && bank < DEF_BANK_COUNT)
        store_img[bank * BANK_BYTES + int'(addr[OFF_W-1:0])] = val;
    end
  endtask

  // Apply one accepted input beat to the image
  task automatic apply_access(input logic [FUNC_W-1:0] kind,
                              input logic [IN_TDATA_W-1:0] beat);
    logic [CPU_AW-1:0]   cpu_addr;
    logic [STORE_AW-1:0] rom_addr;
    logic [DATA_W-1:0]   val;
    cpu_addr = beat[CPU_AW-1:0];
    rom_addr = beat[CPU_AW+STORE_AW-1:CPU_AW];
    val      = beat[CPU_AW+STORE_AW +: DATA_W];
    case (kind)
      FUNC_READ: begin
        read_bytes_q.push_back(bank_byte(cpu_addr));
      end
      FUNC_WRITE: begin
        cpu_write(cpu_addr, val);
      end
      FUNC_PRELOAD: begin
        if (int'(rom_addr) < RomBytes && int'(rom_addr) < StoreBytes)
          store_img[int'(rom_addr)] = val;
      end
      default: ;
    endcase
  endtask

  // Check read beats first, then take the input beat of the same edge
  always @(posedge clk_i) begin : watch
    logic [DATA_W-1:0] owed;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (read_bytes_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("read beat %0d: none owed, got %02h", read_beats, out_data_i);
        end else begin
          owed = read_bytes_q.pop_front();
          // a ROM byte that was never preloaded has no defined value
          if (!$isunknown(owed) && out_data_i !== owed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("read beat %0d: expected %02h, got %02h",
                       read_beats, owed, out_data_i);
          end
        end
        read_beats++;
      end
      if (in_valid_i && in_ready_i) apply_access(in_user_i, in_data_i);
      fail_count_o = mismatches;
      reads_owed_o = read_bytes_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Drives accesses into the bank mapper, throttles the read channel and gives
// the verdict; prediction and comparison live in the checker.
module tb_top;
  import sccbm_pkg::*;

  localparam int               EdgePreloads   = DEF_ROM_BANK_COUNT * 32;
  localparam int               RandomAccesses = 900;
  localparam int               IdleLimit      = 400000;
  localparam int               ChokeCycles    = 300;
  localparam int               DrainCycles    = 20;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED   = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_valid;
  logic                  s_ready;
  logic [IN_TDATA_W-1:0] s_data;
  logic [FUNC_W-1:0]     s_user;
  logic                  m_valid;
  logic                  m_ready;
  logic [DATA_W-1:0]     m_data;
  int                    fail_count;
  int                    reads_owed;
  int                    idle_cycles;
  logic                  calm_in;
  logic                  calm_out;
  logic                  choke_req;

  scc_bank_mapper_with_ram_mode dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  sccbm_read_checker read_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_data_i    (s_data),
    .in_user_i    (s_user),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .fail_count_o (fail_count),
    .reads_owed_o (reads_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // End the run when neither channel moves a beat for too long
  initial idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("** scc_bank_mapper_with_ram_mode: FAILED **");
        $finish;
      end
    end
  end

  // Offer one access after a drawn gap and hold it until it is taken
  task automatic send_access(input logic [FUNC_W-1:0] kind,
                             input logic [CPU_AW-1:0] cpu_addr,
                             input logic [STORE_AW-1:0] rom_addr,
                             input logic [DATA_W-1:0] val);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_user  = kind;
    s_data  = {val, rom_addr, cpu_addr};
    s_valid = 1'b1;
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
  endtask

  function automatic logic [STORE_AW-1:0] any_rom_addr();
    return STORE_AW'($urandom_range(0, (1 << STORE_AW) - 1));
  endfunction

  // Window address, often near the ends of a region so reads find earlier writes
  function automatic logic [CPU_AW-1:0] pick_cpu_addr();
    logic [1:0]       region;
    logic [OFF_W-1:0] off;
    region = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 1) != 0) off = OFF_W'($urandom_range(0, BANK_BYTES - 1));
    else off = ($urandom_range(0, 1) != 0 ? 13'h1FF0 : 13'h0000) | 13'($urandom_range(0, 15));
    return {region, off};
  endfunction

  // Address in the register area with a given low byte
  function automatic logic [CPU_AW-1:0] reg_area_addr(input logic [7:0] low);
    return {4'b0001, 3'($urandom_range(0, 7)), low};
  endfunction

  task automatic random_access();
    int                pick;
    logic [CPU_AW-1:0] addr;
    logic [DATA_W-1:0] val;
    pick = $urandom_range(0, 99);
    addr = pick_cpu_addr();
    val  = DATA_W'($urandom_range(0, 255));
    if (pick < 40) begin
      send_access(FUNC_READ, addr, any_rom_addr(), val);
    end else if (pick < 50) begin
      // mostly switch RAM mode on
      if ($urandom_range(0, 9) < 7) val[0] = 1'b1;
      send_access(FUNC_WRITE, reg_area_addr(LOW_MODE), any_rom_addr(), val);
    end else if (pick < 65) begin
      if ($urandom_range(0, 9) < 6) val[4] = 1'b1;
      send_access(FUNC_WRITE, reg_area_addr(LOW_BANK_FIRST | 8'($urandom_range(0, 3))),
                  any_rom_addr(), val);
    end else if (pick < 75) begin
      if ($urandom_range(0, 9) < 6) val[4] = 1'b1;
      send_access(FUNC_WRITE, {2'($urandom_range(0, 3)), 2'b10, 11'($urandom_range(0, 2047))},
                  any_rom_addr(), val);
    end else if (pick < 93) begin
      send_access(FUNC_WRITE, addr, any_rom_addr(), val);
    end else if (pick < 97) begin
      send_access(FUNC_PRELOAD, addr, any_rom_addr(), val);
    end else begin
      send_access(FUNC_UNUSED, CPU_AW'($urandom_range(0, 32767)), any_rom_addr(), val);
    end
  endtask

  // Read side: random stalls, calm stretches, and one long hold-off on request
  initial begin : read_side
    int   stall;
    logic choke_done;
    choke_done = 1'b0;
    m_ready    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (choke_req && !choke_done) begin
        m_ready = 1'b0;
        repeat (ChokeCycles) @(negedge clk_i);
        choke_done = 1'b1;
      end
      stall = calm_out ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready = 1'b1;
      do @(posedge clk_i); while (!m_valid);
    end
  end

  initial begin : stimulus
    int               idx;
    logic [OFF_W-1:0] edge_off;
    rst_ni    = 1'b0;
    s_valid   = 1'b0;
    s_data    = '0;
    s_user    = FUNC_READ;
    calm_in   = 1'b1;
    calm_out  = 1'b0;
    choke_req = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Preload both ends of every ROM bank back to back
    for (idx = 0; idx < EdgePreloads; idx++) begin
      edge_off = idx[4] ? (13'h1FF0 | 13'(idx[3:0])) : 13'(idx[3:0]);
      send_access(FUNC_PRELOAD, pick_cpu_addr(), {idx[8:5], edge_off},
                  DATA_W'($urandom_range(0, 255)));
    end
    calm_in = 1'b0;

    // Region ends, the unused kind, both bank register forms and the mode flag
    send_access(FUNC_READ,    15'h0000, any_rom_addr(), 8'h00);
    send_access(FUNC_READ,    15'h7FFF, any_rom_addr(), 8'hFF);
    send_access(FUNC_READ,    15'h1FFF, any_rom_addr(), 8'h00);
    send_access(FUNC_READ,    15'h2000, any_rom_addr(), 8'hFF);
    send_access(FUNC_UNUSED,  15'h7FFF, 17'h1FFFF, 8'hFF);
    // value 3Fh is kept and maps bank 1Fh
    send_access(FUNC_WRITE,   15'h5000, any_rom_addr(), 8'hFF);
    send_access(FUNC_READ,    15'h5ABC, any_rom_addr(), 8'h00);
    send_access(FUNC_WRITE,   15'h08FB, any_rom_addr(), 8'h01);
    send_access(FUNC_WRITE,   15'h4123, any_rom_addr(), 8'h77);
    send_access(FUNC_READ,    15'h4123, any_rom_addr(), 8'h00);
    // RAM bank in region 0, stored unless it hits a register address
    send_access(FUNC_WRITE,   15'h0FFC, any_rom_addr(), 8'h10);
    send_access(FUNC_WRITE,   15'h0123, any_rom_addr(), 8'hA5);
    send_access(FUNC_READ,    15'h0123, any_rom_addr(), 8'h00);
    send_access(FUNC_WRITE,   15'h1000, any_rom_addr(), 8'h3C);
    send_access(FUNC_READ,    15'h1000, any_rom_addr(), 8'h00);
    // ROM bank in region 1 drops the write
    send_access(FUNC_WRITE,   15'h0FFD, any_rom_addr(), 8'hE1);
    send_access(FUNC_WRITE,   15'h2010, any_rom_addr(), 8'h55);
    send_access(FUNC_READ,    15'h2010, any_rom_addr(), 8'h00);
    send_access(FUNC_WRITE,   15'h0FFF, any_rom_addr(), 8'h3F);
    send_access(FUNC_WRITE,   15'h7FFF, any_rom_addr(), 8'h00);
    send_access(FUNC_READ,    15'h7FFF, any_rom_addr(), 8'h00);
    send_access(FUNC_PRELOAD, 15'h7FFF, 17'h1FFFF, 8'h00);
    send_access(FUNC_PRELOAD, 15'h0000, 17'h00000, 8'hFF);
    // leave RAM mode; a bank byte address is then a plain ignored write
    send_access(FUNC_WRITE,   15'h0FFB, any_rom_addr(), 8'hFE);
    send_access(FUNC_WRITE,   15'h0FFC, any_rom_addr(), 8'h05);
    send_access(FUNC_READ,    15'h0FFC, any_rom_addr(), 8'h00);
    send_access(FUNC_WRITE,   15'h7000, any_rom_addr(), 8'h02);
    send_access(FUNC_READ,    15'h7000, any_rom_addr(), 8'h00);

    // Hold off the read side while reads keep coming, so the input stalls
    calm_in   = 1'b1;
    choke_req = 1'b1;
    for (idx = 0; idx < 40; idx++)
      send_access(FUNC_READ, pick_cpu_addr(), any_rom_addr(), 8'h00);

    for (idx = 0; idx < RandomAccesses; idx++) begin
      if (idx % 150 == 0) begin
        calm_in  = $urandom_range(0, 3) == 0;
        calm_out = $urandom_range(0, 3) == 0;
      end
      random_access();
    end
    s_valid = 1'b0;

    // Drain outstanding reads, then allow the pipeline to settle
    while (reads_owed != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** scc_bank_mapper_with_ram_mode: PASSED **");
    end else begin
      $display("** scc_bank_mapper_with_ram_mode: FAILED **");
    end
    $finish;
  end

endmodule
